// ===== rtl/rmadd_pkg.sv =====
package rmadd_pkg;

	localparam int INT_W  = 64;
	localparam int NUM_W  = 64;
	localparam int DEN_W  = 63;
	localparam int WIDE_W = 192;
	localparam int CNT_W  = 6;

	localparam logic [NUM_W-1:0] LIM = NUM_W'((65'd1 << (INT_W - 1)) - 65'd1);

	localparam logic CFG_STEP_NUM = 1'b0;
	localparam logic CFG_STEP_DEN = 1'b1;

	typedef struct packed {
		logic             err;
		logic             neg;
		logic [NUM_W-1:0] nmag;
		logic [DEN_W-1:0] dval;
	} item_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MUL,
		F_COMB
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_GCD,
		B_DIV,
		B_DONE
	} back_state_t;

endpackage

// ===== rtl/rmadd_front.sv =====
module rmadd_front import rmadd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [NUM_W-1:0] x_num,
	input  logic [DEN_W-1:0] x_den,
	input  logic [NUM_W-1:0] u_num,
	input  logic [DEN_W-1:0] u_den,
	input  logic [DEN_W-1:0] step_num,
	input  logic [DEN_W-1:0] step_den,
	output logic             push,
	input  logic             push_ready,
	output item_t            push_item
);

	front_state_t state_q, state_d;

	logic [WIDE_W-1:0] mc_q  [3];
	logic [WIDE_W-1:0] acc_q [3];
	logic [DEN_W-1:0]  mp_q  [3];
	logic [DEN_W-1:0]  xd_q;
	logic              pass_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              xneg_q, uneg_q;

	logic [NUM_W-1:0]  xmag, umag;
	logic              last_step;

	logic [WIDE_W-1:0] t1, t2, den, num;
	logic              ge, same, neg, ok_num, ok_den;
	logic [NUM_W-1:0]  nmag;

	assign xmag = x_num[NUM_W-1] ? (~x_num + NUM_W'(1)) : x_num;
	assign umag = u_num[NUM_W-1] ? (~u_num + NUM_W'(1)) : u_num;
	assign last_step = (cnt_q == CNT_W'(DEN_W - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			F_IDLE: if (in_valid) state_d = F_MUL;
			F_MUL:  if (last_step && pass_q) state_d = F_COMB;
			F_COMB: if (push_ready) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == F_IDLE);
		push     = (state_q == F_COMB);
	end

	// sign combine and range check
	always_comb begin
		t1   = acc_q[0];
		t2   = acc_q[1];
		den  = acc_q[2];
		ge   = (t1 >= t2);
		same = (xneg_q == uneg_q);
		if (same) begin
			num = t1 + t2;
			neg = xneg_q;
		end else if (ge) begin
			num = t1 - t2;
			neg = xneg_q;
		end else begin
			num = t2 - t1;
			neg = uneg_q;
		end
		nmag = num[NUM_W-1:0];
		if (num == '0) neg = 1'b0;
		ok_num = (num[WIDE_W-1:NUM_W] == '0) &&
			((nmag <= LIM) || (neg && (nmag == LIM + NUM_W'(1))));
		ok_den = (den[WIDE_W-1:NUM_W] == '0) && (den[NUM_W-1:0] != '0) &&
			(den[NUM_W-1:0] <= LIM);
		push_item.err  = !(ok_num && ok_den);
		push_item.neg  = neg;
		push_item.nmag = nmag;
		push_item.dval = den[DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (in_valid) begin
					mc_q[0]  <= WIDE_W'(xmag);
					mc_q[1]  <= WIDE_W'(umag);
					mc_q[2]  <= WIDE_W'(x_den);
					mp_q[0]  <= u_den;
					mp_q[1]  <= step_num;
					mp_q[2]  <= u_den;
					acc_q[0] <= '0;
					acc_q[1] <= '0;
					acc_q[2] <= '0;
					xd_q     <= x_den;
					xneg_q   <= x_num[NUM_W-1];
					uneg_q   <= u_num[NUM_W-1];
					pass_q   <= 1'b0;
					cnt_q    <= '0;
				end
			end
			F_MUL: begin
				if (last_step && !pass_q) begin
					// second pass multiplies the partial products again
					for (int i = 0; i < 3; i++) begin
						mc_q[i]  <= acc_q[i] + (mp_q[i][0] ? mc_q[i] : '0);
						acc_q[i] <= '0;
					end
					mp_q[0] <= step_den;
					mp_q[1] <= xd_q;
					mp_q[2] <= step_den;
					pass_q  <= 1'b1;
					cnt_q   <= '0;
				end else begin
					for (int i = 0; i < 3; i++) begin
						acc_q[i] <= acc_q[i] + (mp_q[i][0] ? mc_q[i] : '0);
						mc_q[i]  <= mc_q[i] << 1;
						mp_q[i]  <= mp_q[i] >> 1;
					end
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/rmadd_queue.sv =====
module rmadd_queue import rmadd_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_valid,
	output logic  wr_ready,
	input  item_t wr_item,
	output logic  rd_valid,
	input  logic  rd_ready,
	output item_t rd_item
);

	item_t      mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_wr, do_rd;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_item  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_wr) wr_ptr_q <= ~wr_ptr_q;
			if (do_rd) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(do_wr) - 2'(do_rd);
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wr_ptr_q] <= wr_item;
	end

endmodule

// ===== rtl/rmadd_back.sv =====
module rmadd_back import rmadd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pop_valid,
	output logic             pop,
	input  item_t            pop_item,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [NUM_W-1:0] out_num,
	output logic [DEN_W-1:0] out_den,
	output logic             out_err
);

	back_state_t state_q, state_d;

	logic             err_q, neg_q;
	logic [NUM_W-1:0] a_q, b_q, g_q;
	logic [CNT_W-1:0] k_q, cnt_q;
	logic [NUM_W-1:0] dn_q, dd_q;
	logic [NUM_W-1:0] rn_q, rd_q;
	logic             out_valid_q, out_err_q;
	logic [NUM_W-1:0] out_num_q;
	logic [DEN_W-1:0] out_den_q;

	logic             gcd_done, div_done, out_free;
	logic [NUM_W:0]   rn2, rd2;

	assign gcd_done = (a_q == '0);
	assign div_done = (cnt_q == CNT_W'(NUM_W - 1));
	assign out_free = !out_valid_q || out_ready;
	assign rn2      = {rn_q, dn_q[NUM_W-1]};
	assign rd2      = {rd_q, dd_q[NUM_W-1]};

	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: if (pop_valid) state_d = pop_item.err ? B_DONE : B_GCD;
			B_GCD:  if (gcd_done) state_d = B_DIV;
			B_DIV:  if (div_done) state_d = B_DONE;
			B_DONE: if (out_free) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	always_comb begin
		pop = (state_q == B_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == B_DONE && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (pop_valid) begin
					err_q <= pop_item.err;
					neg_q <= pop_item.neg;
					a_q   <= pop_item.nmag;
					b_q   <= NUM_W'(pop_item.dval);
					dn_q  <= pop_item.nmag;
					dd_q  <= NUM_W'(pop_item.dval);
					k_q   <= '0;
				end
			end
			B_GCD: begin
				// binary gcd, one step per cycle
				if (gcd_done) begin
					g_q   <= b_q << k_q;
					rn_q  <= '0;
					rd_q  <= '0;
					cnt_q <= '0;
				end else if (!a_q[0] && !b_q[0]) begin
					a_q <= a_q >> 1;
					b_q <= b_q >> 1;
					k_q <= k_q + CNT_W'(1);
				end else if (!a_q[0]) begin
					a_q <= a_q >> 1;
				end else if (!b_q[0]) begin
					b_q <= b_q >> 1;
				end else if (a_q >= b_q) begin
					a_q <= (a_q - b_q) >> 1;
				end else begin
					b_q <= (b_q - a_q) >> 1;
				end
			end
			B_DIV: begin
				// restoring division of both terms by the gcd
				if (rn2 >= {1'b0, g_q}) begin
					rn_q <= NUM_W'(rn2 - {1'b0, g_q});
					dn_q <= {dn_q[NUM_W-2:0], 1'b1};
				end else begin
					rn_q <= rn2[NUM_W-1:0];
					dn_q <= {dn_q[NUM_W-2:0], 1'b0};
				end
				if (rd2 >= {1'b0, g_q}) begin
					rd_q <= NUM_W'(rd2 - {1'b0, g_q});
					dd_q <= {dd_q[NUM_W-2:0], 1'b1};
				end else begin
					rd_q <= rd2[NUM_W-1:0];
					dd_q <= {dd_q[NUM_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q + CNT_W'(1);
			end
			B_DONE: begin
				if (out_free) begin
					out_err_q <= err_q;
					out_num_q <= err_q ? '0 : (neg_q ? (~dn_q + NUM_W'(1)) : dn_q);
					out_den_q <= err_q ? '0 : dd_q[DEN_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_num   = out_num_q;
	assign out_den   = out_den_q;
	assign out_err   = out_err_q;

endmodule

// ===== rtl/rational_multiply_add_normalize.sv =====
// exact rational update new = x + u * step, reduced by its gcd
// input stream s_axis: one transaction carries x_num, x_den, u_num, u_den
// output stream m_axis: one transaction per input with new_num, new_den in
// tdata and status in tuser (1 = range error, data then zero)
// step_num and step_den are written through cfg_we / cfg_idx / cfg_data by
// the user only while the block is idle (unenforced); both reset to 1
// the front end forms the 192-bit products with three shift-add lanes in two
// passes over the 63-bit multipliers, then combines and range-checks them
// the back end runs a binary gcd and then two 64-bit restoring dividers in
// parallel; error items skip both
// a two-entry queue sits between front and back
// the front end takes a new item once it has pushed the last one into the queue,
// so front and back end overlap; the slower of the two bounds the throughput
// reset clears the state machines, queue and output valid; results in flight are dropped
// a stalled receiver holds the output register; the back end finishes its
// current item, then the queue and the front end fill and s_axis_tready drops
module rational_multiply_add_normalize import rmadd_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// x_num[63:0], x_den[126:64], u_num[190:127], u_den[253:191], zero pad
	input  logic [255:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// new_num[63:0], new_den[126:64], zero pad
	output logic [127:0] m_axis_tdata,
	// status[0]
	output logic         m_axis_tuser,
	input  logic         cfg_we,
	input  logic         cfg_idx,
	input  logic [62:0]  cfg_data
);

	logic [DEN_W-1:0] step_num_q, step_den_q;

	logic             push, push_ready, pop_valid, pop;
	item_t            push_item, pop_item;
	logic [NUM_W-1:0] out_num;
	logic [DEN_W-1:0] out_den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_num_q <= DEN_W'(1);
			step_den_q <= DEN_W'(1);
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_STEP_NUM: step_num_q <= cfg_data;
				CFG_STEP_DEN: step_den_q <= cfg_data;
				default: ;
			endcase
		end
	end

	rmadd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.x_num      (s_axis_tdata[63:0]),
		.x_den      (s_axis_tdata[126:64]),
		.u_num      (s_axis_tdata[190:127]),
		.u_den      (s_axis_tdata[253:191]),
		.step_num   (step_num_q),
		.step_den   (step_den_q),
		.push       (push),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	rmadd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push),
		.wr_ready (push_ready),
		.wr_item  (push_item),
		.rd_valid (pop_valid),
		.rd_ready (pop),
		.rd_item  (pop_item)
	);

	rmadd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop       (pop),
		.pop_item  (pop_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_num   (out_num),
		.out_den   (out_den),
		.out_err   (m_axis_tuser)
	);

	assign m_axis_tdata = {1'b0, out_den, out_num};

`ifndef SYNTHESIS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
		else $error("error result carries nonzero data");
	a_den_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[126:64] != '0)
		else $error("valid result with zero denominator");
	a_zero_num: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser && m_axis_tdata[63:0] == '0
		|-> m_axis_tdata[126:64] == 63'd1)
		else $error("zero numerator not reduced to 0/1");
`endif

endmodule

// ===== tb/tb_rational_multiply_add_normalize.sv =====
module tb_rational_multiply_add_normalize;
	import rmadd_pkg::*;

	localparam longint CYCLE_LIMIT = 4000000;
	localparam logic [63:0] NUM_MAX = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] NUM_MIN = 64'h8000_0000_0000_0000;
	localparam logic [62:0] DEN_MAX = 63'h7fff_ffff_ffff_ffff;

	typedef struct {
		logic [63:0] num;
		logic [62:0] den;
		logic        status;
	} update_t;

	class update_scoreboard;
		logic [62:0] step_num = 63'd1;
		logic [62:0] step_den = 63'd1;
		update_t     pending[$];
		int          errors = 0;
		int          checked = 0;
		int          range_errs = 0;

		task report(string what, logic [63:0] got, logic [63:0] want);
			errors++;
			$display("mismatch at result %0d: %s got %h want %h", checked, what, got, want);
		endtask

		function update_t predict(logic [63:0] xn, logic [62:0] xd, logic [63:0] un,
			logic [62:0] ud);
			logic [63:0]  xa, ua, nm, a, b, t;
			logic [191:0] t1, t2, num, den;
			logic         neg, ok;
			update_t      r;
			xa = xn[63] ? (~xn + 64'd1) : xn;
			ua = un[63] ? (~un + 64'd1) : un;
			t1 = 192'(xa) * 192'(ud) * 192'(step_den);
			t2 = 192'(ua) * 192'(step_num) * 192'(xd);
			den = 192'(xd) * 192'(ud) * 192'(step_den);
			if (xn[63] == un[63]) begin
				num = t1 + t2;
				neg = xn[63];
			end else if (t1 >= t2) begin
				num = t1 - t2;
				neg = xn[63];
			end else begin
				num = t2 - t1;
				neg = un[63];
			end
			ok = (num[191:64] == 0);
			nm = num[63:0];
			if (nm == 0)
				neg = 1'b0;
			if (ok && nm > (neg ? NUM_MIN : NUM_MAX))
				ok = 1'b0;
			if (den[191:63] != 0 || den == 0)
				ok = 1'b0;
			if (!ok) begin
				r.num = 64'd0;
				r.den = 63'd0;
				r.status = 1'b1;
				return r;
			end
			a = nm;
			b = den[63:0];
			while (b != 0) begin
				t = a % b;
				a = b;
				b = t;
			end
			if (a == 0)
				a = 64'd1;
			nm = nm / a;
			r.num = neg ? (~nm + 64'd1) : nm;
			r.den = 63'(den[63:0] / a);
			r.status = 1'b0;
			return r;
		endfunction

		function void note_input(logic [255:0] d);
			pending.push_back(predict(d[63:0], d[126:64], d[190:127], d[253:191]));
		endfunction

		task check_result(logic [127:0] d, logic user);
			update_t e;
			if (pending.size() == 0) begin
				report("unexpected transaction", d[63:0], 64'd0);
				return;
			end
			e = pending.pop_front();
			if (user)
				range_errs++;
			if (d[63:0] !== e.num)
				report("new_num", d[63:0], e.num);
			if (d[126:64] !== e.den)
				report("new_den", 64'(d[126:64]), 64'(e.den));
			if (user !== e.status)
				report("status", 64'(user), 64'(e.status));
			checked++;
		endtask
	endclass

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [255:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [127:0] m_axis_tdata;
	logic         m_axis_tuser;
	logic         cfg_we = 1'b0;
	logic         cfg_idx = 1'b0;
	logic [62:0]  cfg_data = '0;

	update_scoreboard sb = new();
	int     send_idle = 0;
	int     recv_stall = 0;
	int     sent = 0;
	longint cycles = 0;

	rational_multiply_add_normalize dut (.*);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tuser);
		m_axis_tready <= ($urandom_range(99) >= recv_stall);
	end

	task send_item(logic [63:0] xn, logic [62:0] xd, logic [63:0] un, logic [62:0] ud);
		while ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {2'b00, ud, un, xd, xn};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sb.note_input({2'b00, ud, un, xd, xn});
		sent++;
	endtask

	task drain();
		s_axis_tvalid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (350) @(posedge clk);
	endtask

	task write_step(logic [62:0] sn, logic [62:0] sd);
		cfg_we <= 1'b1;
		cfg_idx <= CFG_STEP_NUM;
		cfg_data <= sn;
		@(posedge clk);
		cfg_idx <= CFG_STEP_DEN;
		cfg_data <= sd;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.step_num = sn;
		sb.step_den = sd;
	endtask

	function logic [63:0] rand_num();
		logic [63:0] v;
		case ($urandom_range(9))
			0: v = 64'd0;
			1: v = NUM_MAX;
			2: v = NUM_MIN;
			3, 4: v = 64'($urandom_range(1000));
			5, 6: v = 64'($urandom);
			default: v = {$urandom, $urandom};
		endcase
		if (v != NUM_MIN && $urandom_range(1))
			v = ~v + 64'd1;
		return v;
	endfunction

	function logic [62:0] rand_den();
		case ($urandom_range(9))
			0: return 63'd0;
			1: return DEN_MAX;
			2, 3: return 63'd1;
			4, 5, 6: return 63'($urandom_range(1000, 1));
			7: return 63'($urandom_range(1 << 20, 1));
			default: return 63'({$urandom, $urandom});
		endcase
	endfunction

	initial begin
		logic [62:0] sn, sd;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero denominators, extremes, cancellation, overflow
		send_item(64'd3, 63'd0, 64'd1, 63'd1);
		send_item(64'd3, 63'd1, 64'd1, 63'd0);
		send_item(64'd0, 63'd5, 64'd0, 63'd7);
		send_item(64'd1, 63'd2, -64'sd1, 63'd2);
		send_item(NUM_MIN, 63'd1, 64'd0, 63'd1);
		send_item(NUM_MIN, 63'd1, -64'sd1, 63'd1);
		send_item(NUM_MAX, 63'd1, 64'd0, 63'd1);
		send_item(NUM_MAX, 63'd1, 64'd1, 63'd1);
		send_item(NUM_MIN, 63'd1, NUM_MIN, 63'd1);
		send_item(NUM_MAX, DEN_MAX, NUM_MAX, 63'd1);
		send_item(64'd1, DEN_MAX, 64'd1, 63'd2);
		send_item(64'd6, 63'd4, 64'd10, 63'd6);
		send_item(-64'sd6, 63'd4, 64'd10, 63'd6);
		send_item(NUM_MAX, DEN_MAX, NUM_MIN, DEN_MAX);
		send_item(64'hffff_ffff_ffff_ffff, 63'd3, 64'd1, 63'd3);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin sn = DEN_MAX; sd = 63'd1; end
				1: begin sn = 63'd1; sd = DEN_MAX; end
				2: begin sn = DEN_MAX; sd = DEN_MAX; end
				3: begin sn = 63'd1; sd = 63'd1; end
				default: begin
					sn = 63'($urandom_range(64, 1));
					sd = 63'($urandom_range(64, 1));
				end
			endcase
			write_step(sn, sd);
			send_idle = (ph % 4 == 1) ? 57 : (ph % 4 == 3) ? 36 : 0;
			recv_stall = (ph % 4 == 2) ? 57 : (ph % 4 == 3) ? 36 : 0;
			for (int i = 0; i < 235; i++) begin
				send_item(rand_num(), rand_den(), rand_num(), rand_den());
				if (ph == 5 && i == 100) begin
					s_axis_tvalid <= 1'b0;
					while (sb.pending.size() != 0)
						@(posedge clk);
				end
			end
			drain();
		end

		$display("%0d updates over 9 step settings, %0d range errors, idle and stall phases",
			sent, sb.range_errs);
		$display("%0d results checked, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/rmadd_pkg.sv
rtl/rmadd_front.sv
rtl/rmadd_queue.sv
rtl/rmadd_back.sv
rtl/rational_multiply_add_normalize.sv
tb/tb_rational_multiply_add_normalize.sv
